@@ rtl/rdfi_pkg.sv @@
// shared constants, types and a saturation helper for the radial distortion block
`timescale 1ns / 1ps
package rdfi_pkg;

	localparam int FRAC_BITS      = 28;
	localparam int MAX_ITERATIONS = 16;
	localparam int ITER_W         = 7;
	localparam int QUOT_W         = 64;

	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

	localparam logic [1:0] REG_K1  = 2'd0;
	localparam logic [1:0] REG_K2  = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CAP  = 2'd1;
	localparam logic [1:0] ST_ZDEN = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	// operation codes of the shared arithmetic unit
	typedef enum logic [1:0] {
		ALU_MUL = 2'd0,
		ALU_ADD = 2'd1,
		ALU_SUB = 2'd2
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic signed [31:0] y;
		logic               sat;
	} alu_rsp_t;

	// saturate a 64-bit signed value to 32 bits
	function automatic logic [32:0] sat64(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647) r = {1'b1, 32'h7fffffff};
		else if (v < -64'sd2147483648) r = {1'b1, 32'h80000000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

@@ rtl/radial_distortion_fwd_inv.sv @@
// top level: radial lens distortion, forward polynomial and secant inverse
// forward: six alu steps; inverse: secant loop of n <= 16 iterations
// each iteration runs ten alu steps in the sequencer plus one 64-bit restoring divide
// throughput: one beat at a time, busy is high from start to the result strobe
// reset: asynchronous active low, coefficients and tolerance return to defaults
// results are shown for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
module radial_distortion_fwd_inv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [31:0] radius_in,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] radius_out,
	output logic [1:0]         status,
	output logic [6:0]         iterations_used
);
	// sequencer states
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_ISSUE = 8'b00000010,
		S_WAIT  = 8'b00000100,
		S_CHECK = 8'b00001000,
		S_DIV   = 8'b00010000,
		S_DWAIT = 8'b00100000,
		S_DONE  = 8'b01000000
	} state_t;

	state_t             state_q;
	logic signed [31:0] k1_q, k2_q;
	logic [30:0]        tol_q;
	logic               op_q;
	logic signed [31:0] rad_q, r0_q, r1_q, dr0_q, dr1_q;
	logic signed [31:0] r2_q, t_q, den_q, q_q, acc_q;
	logic               sat_q, zden_q, cap_q;
	logic [6:0]         iter_q;
	logic [3:0]         step_q;   // micro step within one polynomial / secant update
	logic               phase_q;  // declared but not driven or used; the S_WAIT state marks a pending alu result
	rdfi_pkg::alu_req_t req;
	rdfi_pkg::alu_rsp_t rsp;
	logic               div_go, div_done, div_sat;
	logic signed [31:0] div_q;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic signed [31:0] num_c;
	logic               num_ovf;

	rdfi_alu u_alu (.clk(clk), .req(req), .rsp(rsp));
	rdfi_div u_div (.clk(clk), .arst_n(arst_n), .go(div_go), .num(num_c),
		.den(den_q), .done(div_done), .quot(div_q), .sat(div_sat));

	assign busy   = (state_q != S_IDLE);
	assign div_go = (state_q == S_DIV);
	assign diff   = 33'(r1_q) - 33'(r0_q);
	assign mag    = diff[32] ? 33'(-diff) : 33'(diff);

	// secant numerator, saturated to the word
	assign num_ovf = (diff[32] != diff[31]);
	assign num_c   = num_ovf ? (diff[32] ? 32'sh80000000 : 32'sh7fffffff) : diff[31:0];

	// alu step schedule; forward: r2, k2*r2, +k1, *r2, +1, *r
	// inverse adds rad-d, dr1-dr0 before the divide, then dr1*q, r1-step
	always_comb begin
		req.op = rdfi_pkg::ALU_MUL;
		req.a  = '0;
		req.b  = '0;
		unique case (step_q)
			4'd0: begin req.a = acc_q; req.b = acc_q; end
			4'd1: begin req.a = k2_q;  req.b = r2_q; end
			4'd2: begin req.op = rdfi_pkg::ALU_ADD; req.a = t_q; req.b = k1_q; end
			4'd3: begin req.a = t_q;   req.b = r2_q; end
			4'd4: begin req.op = rdfi_pkg::ALU_ADD; req.a = t_q; req.b = rdfi_pkg::ONE_Q; end
			4'd5: begin req.a = t_q;   req.b = acc_q; end
			4'd6: begin req.op = rdfi_pkg::ALU_SUB; req.a = rad_q; req.b = t_q; end
			4'd7: begin req.op = rdfi_pkg::ALU_SUB; req.a = dr1_q; req.b = dr0_q; end
			4'd8: begin req.a = dr1_q; req.b = q_q; end
			4'd9: begin req.op = rdfi_pkg::ALU_SUB; req.a = r1_q; req.b = t_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k1_q    <= 32'sd75161928;
			k2_q    <= 32'sd131533373;
			tol_q   <= 31'd26844;
			done    <= 1'b0;
			step_q  <= '0;
			iter_q  <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					rdfi_pkg::REG_K1:  k1_q  <= cfg_data;
					rdfi_pkg::REG_K2:  k2_q  <= cfg_data;
					rdfi_pkg::REG_TOL: tol_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q   <= operation;
					rad_q  <= radius_in;
					sat_q  <= 1'b0;
					zden_q <= 1'b0;
					cap_q  <= 1'b0;
					iter_q <= '0;
					step_q <= '0;
					r0_q   <= '0;
					r1_q   <= rdfi_pkg::ONE_Q;
					dr0_q  <= radius_in;
					acc_q  <= radius_in;
					state_q <= operation ? S_CHECK : S_ISSUE;
				end
				S_CHECK: begin
					// secant loop head: tolerance, then iteration cap
					if (mag <= {2'b0, tol_q}) state_q <= S_DONE;
					else if (iter_q >= 7'(rdfi_pkg::MAX_ITERATIONS)) begin
						cap_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						iter_q  <= iter_q + 7'd1;
						acc_q   <= r1_q;
						step_q  <= 4'd0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					sat_q <= sat_q | rsp.sat;
					unique case (step_q)
						4'd0: r2_q <= rsp.y;
						4'd7: den_q <= rsp.y;
						4'd6: dr1_q <= rsp.y;
						default: t_q <= rsp.y;
					endcase
					state_q <= S_ISSUE;
					step_q  <= step_q + 4'd1;
					if (step_q == 4'd5 && !op_q) begin
						acc_q   <= rsp.y;
						state_q <= S_DONE;
					end else if (step_q == 4'd7) begin
						if (rsp.y == 32'sd0) begin
							zden_q  <= 1'b1;
							state_q <= S_DONE;
						end else state_q <= S_DIV;
					end else if (step_q == 4'd9) begin
						r0_q    <= r1_q;
						r1_q    <= rsp.y;
						dr0_q   <= dr1_q;
						state_q <= S_CHECK;
					end
				end
				S_DIV: begin
					// numerator clipped to the word counts as saturation
					sat_q   <= sat_q | num_ovf;
					state_q <= S_DWAIT;
				end
				S_DWAIT: if (div_done) begin
					q_q     <= div_q;
					sat_q   <= sat_q | div_sat;
					state_q <= S_ISSUE;
				end
				S_DONE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			radius_out      <= op_q ? r1_q : acc_q;
			iterations_used <= iter_q;
			if (zden_q)     status <= rdfi_pkg::ST_ZDEN;
			else if (sat_q) status <= rdfi_pkg::ST_SAT;
			else if (cap_q) status <= rdfi_pkg::ST_CAP;
			else            status <= rdfi_pkg::ST_OK;
		end
	end
endmodule

@@ rtl/rdfi_alu.sv @@
// shared multiply / add / subtract unit with saturation, registered output
`timescale 1ns / 1ps
module rdfi_alu (
	input  logic                clk,
	input  rdfi_pkg::alu_req_t  req,
	output rdfi_pkg::alu_rsp_t  rsp
);
	logic signed [63:0] wide;
	logic signed [63:0] prod;
	logic [32:0]        s;

	always_comb begin
		prod = 64'(req.a) * 64'(req.b);
		unique case (req.op)
			rdfi_pkg::ALU_MUL: wide = prod >>> rdfi_pkg::FRAC_BITS;
			rdfi_pkg::ALU_ADD: wide = 64'(req.a) + 64'(req.b);
			rdfi_pkg::ALU_SUB: wide = 64'(req.a) - 64'(req.b);
			default:           wide = '0;
		endcase
		s = rdfi_pkg::sat64(wide);
	end

	always_ff @(posedge clk) begin
		rsp.y   <= s[31:0];
		rsp.sat <= s[32];
	end
endmodule

@@ rtl/rdfi_div.sv @@
// restoring divider for the secant quotient, one quotient bit per cycle
`timescale 1ns / 1ps
module rdfi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quot,
	output logic               sat
);
	localparam int DW = rdfi_pkg::QUOT_W;
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [31:0]   dsr_q;
	logic          neg_q;
	logic [6:0]    cnt_q;
	logic          run_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_try;
	logic signed [DW:0] sq;
	logic [32:0]   sres;

	always_comb begin
		rem_sh  = {rem_q[DW-1:0], dvd_q[DW-1]};
		rem_try = rem_sh - {{(DW-31){1'b0}}, dsr_q};
		sq      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		sres    = rdfi_pkg::sat64(sq[63:0]);
		if (sq[DW] != sq[DW-1]) sres = {1'b1, neg_q ? 32'h80000000 : 32'h7fffffff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 7'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= {{(DW-32-rdfi_pkg::FRAC_BITS){1'b0}},
			          (num[31] ? 32'(-num) : 32'(num)), {rdfi_pkg::FRAC_BITS{1'b0}}};
			dsr_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (!rem_try[DW]) begin
				rem_q <= rem_try;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quot = sres[31:0];
	assign sat  = sres[32];
endmodule
